>>> rtl/core/dielectric_fresnel_reflectance_unit_defines.svh
// assertion helpers for the fresnel reflectance unit
`ifndef DIELECTRIC_FRESNEL_REFLECTANCE_UNIT_DEFINES_SVH
`define DIELECTRIC_FRESNEL_REFLECTANCE_UNIT_DEFINES_SVH

// property must hold on every rising clock edge outside reset
`define DFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a condition in the cycle after a trigger
`define DFR_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> rtl/core/dfr_pkg.sv
package dfr_pkg;

    localparam int unsigned CosW    = 16;
    localparam int unsigned IdxW    = 16;
    localparam int unsigned ProdW   = 33;
    localparam int unsigned SumW    = 34;
    localparam int unsigned MagW    = 34;
    localparam int unsigned QuotW   = 16;
    localparam int unsigned ReflW   = 17;
    localparam int unsigned InDataW = 64;
    localparam int unsigned OutDataW = 56;

    localparam logic [ReflW-1:0] ReflOne = 17'h10000;
    localparam logic [MagW-1:0]  DenOne  = 34'h004000000;

    // one step of the restoring divider result fields
    typedef struct packed {
        logic             sat;
        logic [MagW:0]    rem;
        logic [MagW-1:0]  den;
        logic [QuotW-1:0] quo;
    } div_lane_t;

endpackage

>>> rtl/core/dfr_div_lane.sv
// one restoring-division lane: a quotient bit per stage, handshake shared with the top
module dfr_div_lane
    import dfr_pkg::*;
(
    input  logic                   clk,
    input  logic                   adv,
    input  logic [MagW-1:0]        num_mag,
    input  logic [MagW-1:0]        den_mag,
    output logic [ReflW-1:0]       refl
);

    div_lane_t lane_reg [QuotW+1];
    div_lane_t lane_next [QuotW+1];
    logic [2*QuotW-1:0] sq_reg, sq_next;
    logic               sat2_reg, sat2_next;
    logic [ReflW-1:0]   refl_reg, refl_next;

    always_comb
    begin
        logic [MagW-1:0] d;
        logic [MagW:0]   trial;
        d = (den_mag == '0) ? DenOne : den_mag;
        lane_next[0].sat = (num_mag >= d);
        lane_next[0].rem = {1'b0, num_mag};
        lane_next[0].den = d;
        lane_next[0].quo = '0;
        for (int i = 0; i < QuotW; i++)
        begin
            trial = {lane_reg[i].rem[MagW-1:0], 1'b0};
            lane_next[i+1] = lane_reg[i];
            if (trial >= {1'b0, lane_reg[i].den})
            begin
                lane_next[i+1].rem = trial - {1'b0, lane_reg[i].den};
                lane_next[i+1].quo = {lane_reg[i].quo[QuotW-2:0], 1'b1};
            end
            else
            begin
                lane_next[i+1].rem = trial;
                lane_next[i+1].quo = {lane_reg[i].quo[QuotW-2:0], 1'b0};
            end
        end
        sq_next   = lane_reg[QuotW].quo * lane_reg[QuotW].quo;
        sat2_next = lane_reg[QuotW].sat;
        refl_next = sat2_reg ? ReflOne : {1'b0, sq_reg[2*QuotW-1:QuotW]};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i <= QuotW; i++)
                lane_reg[i] <= lane_next[i];
            sq_reg   <= sq_next;
            sat2_reg <= sat2_next;
            refl_reg <= refl_next;
        end
    end

    assign refl = refl_reg;

endmodule

>>> rtl/core/dielectric_fresnel_reflectance_unit.sv
// channel  dir  fields (low bit first)
// s_axis   in   tdata: cos_incident[15:0] cos_transmit[31:16] index_incident[47:32]
//                      index_transmit[63:48]
// m_axis   out  tdata: refl_parallel[16:0] refl_perpendicular[33:17]
//                      refl_unpolarized[50:34], zero fill to 56 bits
// stages: product, sum, 17 divider stages (a setup stage, then one quotient bit each),
// square, saturate, average; one item per cycle sustained while the output is not stalled
// the whole pipe advances when the output register is empty or being taken
// rst_n clears only the valid bits; payload registers are not reset
`include "dielectric_fresnel_reflectance_unit_defines.svh"
module dielectric_fresnel_reflectance_unit
    import dfr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [InDataW-1:0]  s_axis_tdata,   // cos_incident, cos_transmit, index_incident, index_transmit
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OutDataW-1:0] m_axis_tdata    // refl_parallel, refl_perpendicular, refl_unpolarized
);

    localparam int unsigned Depth = QuotW + 6;

    logic adv;
    logic [Depth-1:0] vld_reg, vld_next;

    logic signed [ProdW-1:0] p_ici_reg, p_tct_reg, p_ict_reg, p_tci_reg;
    logic [MagW-1:0] pa_n_reg, pa_d_reg, pe_n_reg, pe_d_reg;
    logic [ReflW-1:0] pa_refl, pe_refl;
    logic [ReflW-1:0] pa_out_reg, pe_out_reg, un_out_reg;

    assign adv = !vld_reg[Depth-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[Depth-1];

    always_comb
    begin
        vld_next = {vld_reg[Depth-2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    function automatic logic [MagW-1:0] mag(input logic signed [SumW-1:0] v);
        mag = v[SumW-1] ? MagW'(-v) : MagW'(v);
    endfunction

    // stage 1: four products, stage 2: sums and magnitudes; also the output registers and average
    always_ff @(posedge clk)
    begin
        logic signed [CosW-1:0] ci, ct;
        logic signed [IdxW:0]   ni, nt;
        logic signed [SumW-1:0] a, b, c, d;
        if (adv)
        begin
            ci = s_axis_tdata[15:0];
            ct = s_axis_tdata[31:16];
            ni = {1'b0, s_axis_tdata[47:32]};
            nt = {1'b0, s_axis_tdata[63:48]};
            p_ici_reg <= ProdW'(ni * ci);
            p_tct_reg <= ProdW'(nt * ct);
            p_ict_reg <= ProdW'(ni * ct);
            p_tci_reg <= ProdW'(nt * ci);
            a = SumW'(p_ici_reg);
            b = SumW'(p_tct_reg);
            c = SumW'(p_ict_reg);
            d = SumW'(p_tci_reg);
            pa_n_reg <= mag(a - b);
            pa_d_reg <= mag(a + b);
            pe_n_reg <= mag(c - d);
            pe_d_reg <= mag(c + d);
            pa_out_reg <= pa_refl;
            pe_out_reg <= pe_refl;
            un_out_reg <= ReflW'(({1'b0, pa_refl} + {1'b0, pe_refl}) >> 1);
        end
    end

    dfr_div_lane u_pa (
        .clk     (clk),
        .adv     (adv),
        .num_mag (pa_n_reg),
        .den_mag (pa_d_reg),
        .refl    (pa_refl)
    );

    dfr_div_lane u_pe (
        .clk     (clk),
        .adv     (adv),
        .num_mag (pe_n_reg),
        .den_mag (pe_d_reg),
        .refl    (pe_refl)
    );

    assign m_axis_tdata = {5'b0, un_out_reg, pe_out_reg, pa_out_reg};

    `DFR_ASSERT(a_out_range, m_axis_tvalid |-> (pa_out_reg <= ReflOne && pe_out_reg <= ReflOne), "reflectance above one")
    `DFR_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `DFR_ASSERT(a_ready, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready does not follow output space")

endmodule

>>> verif/tb_top.sv
module tb_top;
    import dfr_pkg::*;

    typedef struct packed {
        logic [ReflW-1:0] unpol;
        logic [ReflW-1:0] perp;
        logic [ReflW-1:0] par;
    } refl_t;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata;   // cos_incident, cos_transmit, index_incident, index_transmit
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OutDataW-1:0] m_axis_tdata;   // refl_parallel, refl_perpendicular, refl_unpolarized

    refl_t refl_queue[$];
    int    error_count;
    int    idle_cycles;
    bit    hold_off;
    bit    input_gaps;

    dielectric_fresnel_reflectance_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // squared ratio in q1.16, zero denominator taken as 1.0
    function automatic logic [ReflW-1:0] sq_ratio(longint num, longint den);
        longint unsigned n;
        longint unsigned d;
        longint unsigned q;
        if (den == 0)
            den = longint'(1) << 26;
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        if (n >= d)
            return ReflOne;
        q = (n << 16) / d;
        return ReflW'((q * q) >> 16);
    endfunction

    function automatic refl_t fresnel(logic [InDataW-1:0] d);
        longint ci;
        longint ct;
        longint ni;
        longint nt;
        refl_t  r;
        ci = longint'($signed(d[15:0]));
        ct = longint'($signed(d[31:16]));
        ni = longint'(d[47:32]);
        nt = longint'(d[63:48]);
        r.par   = sq_ratio(ni * ci - nt * ct, ni * ci + nt * ct);
        r.perp  = sq_ratio(ni * ct - nt * ci, ni * ct + nt * ci);
        r.unpol = ReflW'(({1'b0, r.par} + {1'b0, r.perp}) >> 1);
        return r;
    endfunction

    task automatic send_item(logic [15:0] ci, logic [15:0] ct, logic [15:0] ni,
                             logic [15:0] nt);
        int g;
        g = input_gaps ? gap_len() : 0;
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {nt, ni, ct, ci};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        refl_queue.push_back(fresnel({nt, ni, ct, ci}));
    endtask

    task automatic finish_burst();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (refl_queue.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] rand_cos();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return 16'($urandom_range(0, 32768) - 16384);
        else
            return 16'($urandom);
    endfunction

    function automatic logic [15:0] rand_index();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return 16'($urandom_range(4096, 12288));
        else
            return 16'($urandom);
    endfunction

    task automatic test_extremes();
        input_gaps = 1'b1;
        send_item(16'd16384, 16'd16384, 16'd4096, 16'd6144);
        send_item(16'd0, 16'd0, 16'd4096, 16'd4096);        // both denominators zero
        send_item(16'hC000, 16'd16384, 16'd4096, 16'd4096); // zero sum, nonzero difference
        send_item(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
        send_item(16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000);
        send_item(16'h7FFF, 16'h7FFF, 16'h0000, 16'hFFFF);
        send_item(16'd16384, 16'd0, 16'd4096, 16'd6144);    // ratio at one, saturates
        send_item(16'hFFFF, 16'd1, 16'd1, 16'd1);
        send_item(16'd11585, 16'd8000, 16'd4096, 16'd6144);
        send_item(16'd1, 16'd16384, 16'hFFFF, 16'd1);
        send_item(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
        send_item(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
        send_item(16'd0, 16'd16384, 16'd0, 16'd4096);
        finish_burst();
        wait_drained();
    endtask

    task automatic test_random(int count, bit gaps);
        input_gaps = gaps;
        repeat (count)
            send_item(rand_cos(), rand_cos(), rand_index(), rand_index());
        finish_burst();
    endtask

    // output side holds off while input keeps offering, filling the pipe
    task automatic test_backpressure();
        hold_off = 1'b1;
        test_random(60, 1'b0);
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        refl_t got;
        refl_t exp_r;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = refl_t'(m_axis_tdata[3*ReflW-1:0]);
            if (refl_queue.size() == 0)
            begin
                $display("%0t unexpected transfer %h", $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                exp_r = refl_queue.pop_front();
                if (got.par !== exp_r.par)
                begin
                    $display("%0t refl_parallel exp %h got %h", $time, exp_r.par, got.par);
                    error_count++;
                end
                if (got.perp !== exp_r.perp)
                begin
                    $display("%0t refl_perpendicular exp %h got %h", $time, exp_r.perp,
                             got.perp);
                    error_count++;
                end
                if (got.unpol !== exp_r.unpol)
                begin
                    $display("%0t refl_unpolarized exp %h got %h", $time, exp_r.unpol,
                             got.unpol);
                    error_count++;
                end
            end
        end
    end

    // receiver stalls, short mostly, with stretches of none
    initial
    begin
        int g;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                // long hold counted here
                m_axis_tready <= 1'b0;
                repeat (149) @(posedge clk);
                hold_off = 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                g = gap_len();
                if (g == 0)
                    m_axis_tready <= 1'b1;
                else
                begin
                    m_axis_tready <= 1'b0;
                    repeat (g - 1) @(posedge clk);
                end
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
        begin
            $display("dielectric_fresnel_reflectance_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        error_count   = 0;
        idle_cycles   = 0;
        hold_off      = 1'b0;
        input_gaps    = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_backpressure();
        test_random(400, 1'b0);
        wait_drained();
        test_random(1400, 1'b1);
        wait_drained();
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("dielectric_fresnel_reflectance_unit verification clean");
        else
            $display("dielectric_fresnel_reflectance_unit verification failed");
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/dfr_pkg.sv
rtl/core/dfr_div_lane.sv
rtl/core/dielectric_fresnel_reflectance_unit.sv
verif/tb_top.sv
